### rtl/core/eml_pkg.sv
package eml_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GROUP_LOG    = 3'd0,
        REG_GROUP_BLOCKS = 3'd1,
        REG_GROUP_COUNT  = 3'd2,
        REG_TOTAL_BLOCKS = 3'd3,
        REG_BLOCK_LOG    = 3'd4
    } eml_reg_t;

    // Answer codes
    localparam logic [1:0] ST_MAPPED  = 2'd0;
    localparam logic [1:0] ST_HOLE    = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;

    // Record field widths
    localparam int START_W = 54;
    localparam int FSB_W   = 52;
    localparam int LEN_W   = 21;
    localparam int END_W   = START_W + 1;
    localparam int GEO_W   = 32;

    // Queue between classifier and geometry pipeline
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [5:0]  group_log;
        logic [31:0] group_blocks;
        logic [31:0] group_count;
        logic [63:0] total_blocks;
        logic [4:0]  block_log;
    } eml_cfg_t;

    localparam eml_cfg_t CFG_RESET = '{
        group_log:    6'd16,
        group_blocks: 32'd65536,
        group_count:  32'd1,
        total_blocks: 64'd65536,
        block_log:    5'd12
    };

    // What a record decided for its run
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_CORRUPT = 2'd1,
        KIND_HIT     = 2'd2
    } eml_kind_t;

    typedef struct packed {
        eml_kind_t          kind;
        logic               last;
        logic               unwritten;
        logic [FSB_W-1:0]   fsb;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   off;
    } eml_entry_t;

endpackage

### rtl/core/eml_if.sv
interface eml_rec_if;
    logic        valid;
    logic        ready;
    logic [63:0] record_high;
    logic [63:0] record_low;
    logic [63:0] query_block;
    logic        last_record;

    modport source (output valid, output record_high, output record_low,
                    output query_block, output last_record, input ready);
    modport sink   (input valid, input record_high, input record_low,
                    input query_block, input last_record, output ready);
endinterface

interface eml_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] byte_offset;

    modport source (output valid, output status, output byte_offset, input ready);
    modport sink   (input valid, input status, input byte_offset, output ready);
endinterface

### rtl/core/eml_front.sv
module eml_front
    import eml_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    eml_rec_if.sink    rec,
    input  logic       q_full,
    output logic       q_push,
    output eml_entry_t q_data
);

    logic [START_W-1:0] start;
    logic [FSB_W-1:0]   fsb;
    logic [LEN_W-1:0]   len;
    logic [END_W-1:0]   rec_end;
    logic               accept;
    logic               take;
    logic               bad;
    logic               covers;

    logic [END_W-1:0]   prior_end_reg, prior_end_next;
    logic               first_reg, first_next;
    logic               settled_reg, settled_next;

    // Unpack the record
    assign start   = rec.record_high[62:9];
    assign fsb     = {rec.record_high[8:0], rec.record_low[63:21]};
    assign len     = rec.record_low[LEN_W-1:0];
    assign rec_end = END_W'(start) + END_W'(len);

    assign rec.ready = !q_full;
    assign accept    = rec.valid && rec.ready;

    // Classify against the run state
    assign take   = !settled_reg;
    assign bad    = (len == '0) || (!first_reg && (END_W'(start) < prior_end_reg));
    assign covers = (rec.query_block >= 64'(start)) && (rec.query_block < 64'(rec_end));

    always_comb
    begin
        prior_end_next = prior_end_reg;
        first_next     = first_reg;
        settled_next   = settled_reg;
        if (accept)
        begin
            if (rec.last_record)
            begin
                prior_end_next = '0;
                first_next     = 1'b1;
                settled_next   = 1'b0;
            end
            else if (take)
            begin
                first_next = 1'b0;
                if (bad)
                begin
                    settled_next = 1'b1;
                end
                else
                begin
                    prior_end_next = rec_end;
                    settled_next   = covers;
                end
            end
        end
    end

    // Build the queue request
    always_comb
    begin
        q_push           = accept;
        q_data.last      = rec.last_record;
        q_data.unwritten = rec.record_high[63];
        q_data.fsb       = fsb;
        q_data.len       = len;
        q_data.off       = LEN_W'(rec.query_block - 64'(start));
        if (!take)
        begin
            q_data.kind = KIND_NONE;
        end
        else if (bad)
        begin
            q_data.kind = KIND_CORRUPT;
        end
        else if (covers)
        begin
            q_data.kind = KIND_HIT;
        end
        else
        begin
            q_data.kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_end_reg <= '0;
            first_reg     <= 1'b1;
            settled_reg   <= 1'b0;
        end
        else
        begin
            prior_end_reg <= prior_end_next;
            first_reg     <= first_next;
            settled_reg   <= settled_next;
        end
    end

endmodule

### rtl/core/eml_queue.sv
module eml_queue
    import eml_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  eml_entry_t push_data,
    input  logic       pop,
    output logic       full,
    output logic       empty,
    output eml_entry_t head
);

    eml_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/eml_back.sv
module eml_back
    import eml_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  eml_cfg_t   cfg,
    input  logic       q_empty,
    input  eml_entry_t q_head,
    output logic       q_pop,
    eml_res_if.source  res
);

    typedef struct packed {
        eml_kind_t        kind;
        logic             last;
        logic             unwritten;
        logic             ok;
        logic [GEO_W-1:0] ag_end;
        logic [GEO_W-1:0] blk_end;
        logic [GEO_W-1:0] ag_qry;
        logic [GEO_W-1:0] blk_qry;
    } geo_t;

    typedef struct packed {
        eml_kind_t   kind;
        logic        last;
        logic        unwritten;
        logic        ok;
        logic [63:0] lin_end;
        logic [63:0] lin_qry;
    } lin_t;

    logic             adv;
    logic [FSB_W:0]   fsb_end;
    logic [FSB_W:0]   fsb_qry;
    logic [63:0]      mask;
    logic [63:0]      agb;
    logic [63:0]      ag_end;
    logic [63:0]      blk_end;
    logic [63:0]      ag_qry;
    logic [63:0]      blk_qry;
    logic [63:0]      gb64;
    logic [63:0]      gc64;
    logic [63:0]      lim;
    logic             ok_c;
    logic [1:0]       new_status;
    logic [63:0]      new_offset;

    logic             a_valid_reg, a_valid_next;
    geo_t             a_reg, a_next;
    logic             b_valid_reg, b_valid_next;
    lin_t             b_reg, b_next;
    logic [1:0]       held_status_reg, held_status_next;
    logic [63:0]      held_offset_reg, held_offset_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_status_reg, out_status_next;
    logic [63:0]      out_offset_reg, out_offset_next;

    // Stall the whole pipeline only while a result waits
    assign adv   = !out_valid_reg || res.ready;
    assign q_pop = adv && !q_empty;

    // Split both target blocks into group and block within group
    assign gb64    = 64'(cfg.group_blocks);
    assign gc64    = 64'(cfg.group_count);
    assign fsb_end = (FSB_W+1)'(q_head.fsb) + (FSB_W+1)'(q_head.len) - (FSB_W+1)'(1);
    assign fsb_qry = (FSB_W+1)'(q_head.fsb) + (FSB_W+1)'(q_head.off);
    assign mask    = ~({64{1'b1}} << cfg.group_log);
    assign agb     = 64'(q_head.fsb) & mask;
    assign ag_end  = 64'(fsb_end) >> cfg.group_log;
    assign blk_end = 64'(fsb_end) & mask;
    assign ag_qry  = 64'(fsb_qry) >> cfg.group_log;
    assign blk_qry = 64'(fsb_qry) & mask;

    always_comb
    begin
        a_next.kind      = q_head.kind;
        a_next.last      = q_head.last;
        a_next.unwritten = q_head.unwritten;
        a_next.ok        = (agb < gb64) && (64'(q_head.len) <= gb64 - agb)
                           && (ag_end < gc64) && (blk_end < gb64)
                           && (ag_qry < gc64) && (blk_qry < gb64);
        a_next.ag_end    = ag_end[GEO_W-1:0];
        a_next.blk_end   = blk_end[GEO_W-1:0];
        a_next.ag_qry    = ag_qry[GEO_W-1:0];
        a_next.blk_qry   = blk_qry[GEO_W-1:0];
    end

    // Form linear block numbers
    always_comb
    begin
        b_next.kind      = a_reg.kind;
        b_next.last      = a_reg.last;
        b_next.unwritten = a_reg.unwritten;
        b_next.ok        = a_reg.ok;
        b_next.lin_end   = 64'(a_reg.ag_end) * 64'(cfg.group_blocks) + 64'(a_reg.blk_end);
        b_next.lin_qry   = 64'(a_reg.ag_qry) * 64'(cfg.group_blocks) + 64'(a_reg.blk_qry);
    end

    // Check volume size and byte overflow, then settle the answer
    assign lim  = {64{1'b1}} >> cfg.block_log;
    assign ok_c = b_reg.ok
                  && (b_reg.lin_end < cfg.total_blocks) && (b_reg.lin_end <= lim)
                  && (b_reg.lin_qry < cfg.total_blocks) && (b_reg.lin_qry <= lim);

    always_comb
    begin
        unique case (b_reg.kind)
            KIND_CORRUPT:
            begin
                new_status = ST_CORRUPT;
                new_offset = '0;
            end
            KIND_HIT:
            begin
                if (ok_c)
                begin
                    new_status = b_reg.unwritten ? ST_HOLE : ST_MAPPED;
                    new_offset = b_reg.lin_qry << cfg.block_log;
                end
                else
                begin
                    new_status = ST_CORRUPT;
                    new_offset = '0;
                end
            end
            default:
            begin
                new_status = held_status_reg;
                new_offset = held_offset_reg;
            end
        endcase
    end

    // Advance stages, hold the run answer, emit on the last record
    always_comb
    begin
        a_valid_next     = a_valid_reg;
        b_valid_next     = b_valid_reg;
        held_status_next = held_status_reg;
        held_offset_next = held_offset_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_offset_next  = out_offset_reg;
        if (adv)
        begin
            a_valid_next    = q_pop;
            b_valid_next    = a_valid_reg;
            out_valid_next  = b_valid_reg && b_reg.last;
            out_status_next = new_status;
            out_offset_next = new_offset;
            if (b_valid_reg)
            begin
                if (b_reg.last)
                begin
                    held_status_next = ST_HOLE;
                    held_offset_next = '0;
                end
                else
                begin
                    held_status_next = new_status;
                    held_offset_next = new_offset;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            held_status_reg <= ST_HOLE;
            held_offset_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= a_valid_next;
            b_valid_reg     <= b_valid_next;
            held_status_reg <= held_status_next;
            held_offset_reg <= held_offset_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        out_status_reg <= out_status_next;
        out_offset_reg <= out_offset_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.status      = out_status_reg;
    assign res.byte_offset = out_offset_reg;

endmodule

### rtl/core/extent_map_lookup.sv
// Extent list lookup: takes one 128-bit extent record per cycle while rec.ready is
// high, together with the queried file block and a last-record mark, and returns one
// answer (mapped, hole or corrupt, with a byte offset) per record list, on the request
// that carries the last record. Sustained rate is one record per clock unless the
// answer channel stalls; a list of N records answers after N requests. A front
// classifier checks record order and coverage and pushes each record into a 4-entry
// queue; a back pipeline of two register stages (group split, then two 32x32
// multiplies for the linear block) feeds the volume and overflow checks into the
// output register. rec.ready drops only when the queue is full, which happens only
// after the answer channel has stalled. Configuration is written through
// cfg_write/cfg_index/cfg_data and must only change while no list is in flight.
module extent_map_lookup
    import eml_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    eml_rec_if.sink                rec,
    eml_res_if.source              res,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    eml_cfg_t   cfg_reg, cfg_next;
    logic       q_push;
    eml_entry_t q_data;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    eml_entry_t q_head;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GROUP_LOG:    cfg_next.group_log    = cfg_data[5:0];
                REG_GROUP_BLOCKS: cfg_next.group_blocks = cfg_data[31:0];
                REG_GROUP_COUNT:  cfg_next.group_count  = cfg_data[31:0];
                REG_TOTAL_BLOCKS: cfg_next.total_blocks = cfg_data[63:0];
                REG_BLOCK_LOG:    cfg_next.block_log    = cfg_data[4:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    eml_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rec    (rec),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    eml_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    eml_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

### rtl/core/eml_checker.sv
module eml_checker
    import eml_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic [63:0] out_offset
);

    // Hold a stalled answer
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("answer dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status) && $stable(out_offset))
        else $error("answer changed while stalled");

    // Answer codes stay within the defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ST_MAPPED) || (out_status == ST_HOLE)
                      || (out_status == ST_CORRUPT))
        else $error("undefined answer code");

    // A corrupt list carries no offset
    a_corrupt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_CORRUPT) |-> (out_offset == '0))
        else $error("corrupt answer with nonzero offset");

endmodule

bind extent_map_lookup eml_checker u_eml_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_status (res.status),
    .out_offset (res.byte_offset)
);
